FILE: hdl/assert_macros.svh
// Assertion shorthands shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define HVRR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define HVRR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/hvrr_pkg.sv
package hvrr_pkg;

  localparam int SECTOR_W       = 48;
  localparam int BYTES_W        = 24;
  localparam int COUNTER_W      = 64;
  localparam int NUM_COUNTERS   = 16;
  localparam int CNT_IDX_W      = 4;
  localparam int CFG_IDX_W      = 4;
  localparam int SECTOR_SHIFT   = 9;
  localparam int SECTOR_WIDTH_DEFAULT = 48;

  // First sector of the group descriptor region.
  localparam logic [SECTOR_W-1:0] GDT_START = 48'd8;

  // Register reset values.
  localparam logic [SECTOR_W-1:0] DATA_START_RST   = 48'd19922944;
  localparam logic [SECTOR_W-1:0] RESERVE_START_RST = 48'd15728640;
  localparam logic [SECTOR_W-1:0] JOURNAL_START_RST = 48'd15466496;
  localparam logic [SECTOR_W-1:0] ITABLE_START_RST  = 48'd67800;
  localparam logic [SECTOR_W-1:0] IBITMAP_START_RST = 48'd38000;
  localparam logic [SECTOR_W-1:0] BBITMAP_START_RST = 48'd8200;
  localparam logic [SECTOR_W-1:0] REMAP_OFFSET_RST  = 48'd262144;
  localparam logic [1:0]          DISCARD_SUPPORT_RST = 2'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DATA_START      = 4'd0,
    REG_RESERVE_START   = 4'd1,
    REG_JOURNAL_START   = 4'd2,
    REG_ITABLE_START    = 4'd3,
    REG_IBITMAP_START   = 4'd4,
    REG_BBITMAP_START   = 4'd5,
    REG_REMAP_OFFSET    = 4'd6,
    REG_DISCARD_SUPPORT = 4'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_FORWARD = 2'd0,
    KIND_FLUSH   = 2'd1,
    KIND_DONE    = 2'd2,
    KIND_COUNTER = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REGION_SUPER   = 3'd0,
    REGION_GDT     = 3'd1,
    REGION_BBITMAP = 3'd2,
    REGION_IBITMAP = 3'd3,
    REGION_ITABLE  = 3'd4,
    REGION_JOURNAL = 3'd5,
    REGION_RESERVE = 3'd6,
    REGION_DATA    = 3'd7
  } region_t;

  // Up to two byte-counter updates per cycle (a split touches two counters).
  typedef struct packed {
    logic                 en_a;
    logic [CNT_IDX_W-1:0] idx_a;
    logic [BYTES_W-1:0]   bytes_a;
    logic                 en_b;
    logic [CNT_IDX_W-1:0] idx_b;
    logic [BYTES_W-1:0]   bytes_b;
  } cnt_upd_t;

endpackage

FILE: hdl/hvrr_counters.sv
`include "assert_macros.svh"

module hvrr_counters (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  hvrr_pkg::cnt_upd_t                   upd,
  input  logic [hvrr_pkg::CNT_IDX_W-1:0]       rd_idx,
  output logic [hvrr_pkg::COUNTER_W-1:0]       rd_data
);

  logic [hvrr_pkg::NUM_COUNTERS-1:0][hvrr_pkg::COUNTER_W-1:0] cnt_r;
  logic [hvrr_pkg::NUM_COUNTERS-1:0][hvrr_pkg::COUNTER_W-1:0] cnt_nxt;

  // Each counter adds whatever of the two updates addresses it.
  always_comb begin
    logic [hvrr_pkg::BYTES_W:0] inc;
    for (int i = 0; i < hvrr_pkg::NUM_COUNTERS; i++) begin
      inc = '0;
      if (upd.en_a && upd.idx_a == hvrr_pkg::CNT_IDX_W'(i)) begin
        inc = inc + {1'b0, upd.bytes_a};
      end
      if (upd.en_b && upd.idx_b == hvrr_pkg::CNT_IDX_W'(i)) begin
        inc = inc + {1'b0, upd.bytes_b};
      end
      cnt_nxt[i] = cnt_r[i] + hvrr_pkg::COUNTER_W'(inc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign rd_data = cnt_r[rd_idx];

  `HVRR_ASSERT_ALWAYS(a_cnt_clear, !rst_n |=> cnt_r == '0, "counters not cleared by reset")
  `HVRR_ASSERT(a_cnt_idle, !upd.en_a && !upd.en_b |=> $stable(cnt_r), "counter moved without update")
  `HVRR_ASSERT(a_cnt_split, upd.en_b |-> upd.en_a && upd.idx_b[3:1] == hvrr_pkg::REGION_DATA && upd.idx_a[3:1] != hvrr_pkg::REGION_DATA, "bad split counter update")

endmodule

FILE: hdl/hybrid_volume_request_router.sv
// Channel   Direction  Handshake          Carries
// in_*      input      in_valid/in_stall  block request or counter read word
// out_*     output     out_valid/out_stall one result word
// cfg_*     input      cfg_valid/cfg_ready register write (index, data)
//
// One word enters per cycle while in_stall is low; it passes through the input
// register and then the output register, where its result word is presented.
// A request that crosses data_start yields two result words; the second piece is
// held apart and sent before the next word in the input register may advance.
// Reset (rst_n low, synchronous) restores register defaults and zeroes counters.
// out_stall holds the output word and, through it, the input register.
// cfg_ready is always high; write only while the router holds no word.

`include "assert_macros.svh"

module hybrid_volume_request_router #(
  parameter int SECTOR_WIDTH = hvrr_pkg::SECTOR_WIDTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_action,
  input  logic [hvrr_pkg::SECTOR_W-1:0]       in_start_sector,
  input  logic [hvrr_pkg::BYTES_W-1:0]        in_byte_count,
  input  logic                                in_is_write,
  input  logic                                in_is_flush,
  input  logic                                in_is_discard,
  input  logic [hvrr_pkg::CNT_IDX_W-1:0]      in_counter_index,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_kind,
  output logic                                out_target_device,
  output logic [hvrr_pkg::SECTOR_W-1:0]       out_sector,
  output logic [hvrr_pkg::BYTES_W-1:0]        out_bytes,
  output logic                                out_last,
  output logic [hvrr_pkg::COUNTER_W-1:0]      out_counter_value,
  // configuration channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hvrr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hvrr_pkg::SECTOR_W-1:0]       cfg_data
);

  localparam int SW = hvrr_pkg::SECTOR_W;
  localparam int BW = hvrr_pkg::BYTES_W;
  localparam int MASK_BITS = (SECTOR_WIDTH < SW) ? SECTOR_WIDTH : SW;
  localparam logic [SW-1:0] SECTOR_MASK = {SW{1'b1}} >> (SW - MASK_BITS);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [SW-1:0] data_start_r, reserve_start_r, journal_start_r;
  logic [SW-1:0] itable_start_r, ibitmap_start_r, bbitmap_start_r, remap_offset_r;
  logic [1:0]    discard_support_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_start_r      <= hvrr_pkg::DATA_START_RST;
      reserve_start_r   <= hvrr_pkg::RESERVE_START_RST;
      journal_start_r   <= hvrr_pkg::JOURNAL_START_RST;
      itable_start_r    <= hvrr_pkg::ITABLE_START_RST;
      ibitmap_start_r   <= hvrr_pkg::IBITMAP_START_RST;
      bbitmap_start_r   <= hvrr_pkg::BBITMAP_START_RST;
      remap_offset_r    <= hvrr_pkg::REMAP_OFFSET_RST;
      discard_support_r <= hvrr_pkg::DISCARD_SUPPORT_RST;
    end else if (cfg_valid && cfg_ready) begin
      // Drop writes to indexes past the register list.
      unique case (cfg_index)
        hvrr_pkg::REG_DATA_START:      data_start_r      <= cfg_data;
        hvrr_pkg::REG_RESERVE_START:   reserve_start_r   <= cfg_data;
        hvrr_pkg::REG_JOURNAL_START:   journal_start_r   <= cfg_data;
        hvrr_pkg::REG_ITABLE_START:    itable_start_r    <= cfg_data;
        hvrr_pkg::REG_IBITMAP_START:   ibitmap_start_r   <= cfg_data;
        hvrr_pkg::REG_BBITMAP_START:   bbitmap_start_r   <= cfg_data;
        hvrr_pkg::REG_REMAP_OFFSET:    remap_offset_r    <= cfg_data;
        hvrr_pkg::REG_DISCARD_SUPPORT: discard_support_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic                             s1_valid_r;
  logic                             s1_action_r;
  logic [SW-1:0]                    s1_sector_r;
  logic [BW-1:0]                    s1_bytes_r;
  logic                             s1_wr_r, s1_flush_r, s1_discard_r;
  logic [hvrr_pkg::CNT_IDX_W-1:0]   s1_cidx_r;

  // Output register and the held second piece of a split request.
  logic                             out_valid_r;
  hvrr_pkg::kind_t                  out_kind_r;
  logic                             out_dev_r;
  logic [SW-1:0]                    out_sector_r;
  logic [BW-1:0]                    out_bytes_r;
  logic                             out_last_r;
  logic [hvrr_pkg::COUNTER_W-1:0]   out_cval_r;
  logic                             sec_valid_r;
  logic [SW-1:0]                    sec_sector_r;
  logic [BW-1:0]                    sec_bytes_r;

  logic out_take, out_free, sec_move, s1_adv, in_take;

  assign out_take = out_valid_r && !out_stall;
  assign out_free = !out_valid_r || out_take;
  // The held second piece goes first; the input register waits behind it.
  assign sec_move = sec_valid_r && out_free;
  assign s1_adv   = s1_valid_r && out_free && !sec_valid_r;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action_r  <= in_action;
      s1_sector_r  <= in_start_sector;
      s1_bytes_r   <= in_byte_count;
      s1_wr_r      <= in_is_write;
      s1_flush_r   <= in_is_flush;
      s1_discard_r <= in_is_discard;
      s1_cidx_r    <= in_counter_index;
    end
  end

  // ---------------------------------------------------------------------------
  // Routing: compare, subtract and add on the registered request
  // ---------------------------------------------------------------------------
  logic                   ge_data, crosses, split, is_req;
  logic [SW:0]            end_sector;
  logic [SW-1:0]          gap, data_sector, meta_sector, sec_sector_nxt;
  logic [BW-1:0]          first_bytes, second_bytes;
  hvrr_pkg::region_t      meta_region;
  hvrr_pkg::kind_t        kind_nxt;
  logic                   dev_nxt;
  logic [SW-1:0]          sector_nxt;
  logic [BW-1:0]          bytes_nxt;
  logic [hvrr_pkg::COUNTER_W-1:0] cval_rd;
  hvrr_pkg::cnt_upd_t     upd;

  always_comb begin
    ge_data      = s1_sector_r >= data_start_r;
    end_sector   = {1'b0, s1_sector_r}
                 + (SW+1)'(s1_bytes_r[BW-1:hvrr_pkg::SECTOR_SHIFT]);
    crosses      = end_sector > {1'b0, data_start_r};
    gap          = data_start_r - s1_sector_r;
    // On a crossing the gap stays below the request's sector count, so it fits.
    first_bytes  = {gap[BW-hvrr_pkg::SECTOR_SHIFT-1:0], {hvrr_pkg::SECTOR_SHIFT{1'b0}}};
    second_bytes = s1_bytes_r - first_bytes;
    data_sector  = (s1_sector_r - data_start_r + remap_offset_r) & SECTOR_MASK;
    meta_sector  = (s1_sector_r + remap_offset_r) & SECTOR_MASK;
    sec_sector_nxt = remap_offset_r & SECTOR_MASK;
    is_req       = !s1_action_r && !s1_flush_r;
    split        = is_req && !ge_data && crosses;
  end

  // Metadata region: first start reached, checked from reserve downwards.
  always_comb begin
    priority if (s1_sector_r >= reserve_start_r) meta_region = hvrr_pkg::REGION_RESERVE;
    else if (s1_sector_r >= journal_start_r)     meta_region = hvrr_pkg::REGION_JOURNAL;
    else if (s1_sector_r >= itable_start_r)      meta_region = hvrr_pkg::REGION_ITABLE;
    else if (s1_sector_r >= ibitmap_start_r)     meta_region = hvrr_pkg::REGION_IBITMAP;
    else if (s1_sector_r >= bbitmap_start_r)     meta_region = hvrr_pkg::REGION_BBITMAP;
    else if (s1_sector_r >= hvrr_pkg::GDT_START) meta_region = hvrr_pkg::REGION_GDT;
    else                                         meta_region = hvrr_pkg::REGION_SUPER;
  end

  // First (or only) result word.
  always_comb begin
    dev_nxt    = 1'b0;
    sector_nxt = '0;
    bytes_nxt  = '0;
    priority if (s1_action_r) begin
      kind_nxt = hvrr_pkg::KIND_COUNTER;
    end else if (s1_flush_r) begin
      kind_nxt = hvrr_pkg::KIND_FLUSH;
    end else if (split) begin
      kind_nxt   = hvrr_pkg::KIND_FORWARD;
      sector_nxt = meta_sector;
      bytes_nxt  = first_bytes;
    end else begin
      dev_nxt    = ge_data;
      sector_nxt = ge_data ? data_sector : meta_sector;
      bytes_nxt  = s1_bytes_r;
      // Complete a discard the target device cannot take.
      kind_nxt   = (s1_discard_r && !discard_support_r[ge_data]) ?
                   hvrr_pkg::KIND_DONE : hvrr_pkg::KIND_FORWARD;
    end
  end

  // Byte accounting, applied as the request leaves the input register.
  always_comb begin
    upd.en_a    = s1_adv && is_req;
    upd.idx_a   = {(ge_data ? hvrr_pkg::REGION_DATA : meta_region), s1_wr_r};
    upd.bytes_a = split ? first_bytes : s1_bytes_r;
    upd.en_b    = s1_adv && split;
    upd.idx_b   = {hvrr_pkg::REGION_DATA, s1_wr_r};
    upd.bytes_b = second_bytes;
  end

  hvrr_counters u_counters (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (upd),
    .rd_idx  (s1_cidx_r),
    .rd_data (cval_rd)
  );

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sec_valid_r <= 1'b0;
    end else begin
      if (sec_move || s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
      if (sec_move) begin
        sec_valid_r <= 1'b0;
      end else if (s1_adv && split) begin
        sec_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sec_move) begin
      out_kind_r   <= hvrr_pkg::KIND_FORWARD;
      out_dev_r    <= 1'b1;
      out_sector_r <= sec_sector_r;
      out_bytes_r  <= sec_bytes_r;
      out_last_r   <= 1'b1;
      out_cval_r   <= '0;
    end else if (s1_adv) begin
      out_kind_r   <= kind_nxt;
      out_dev_r    <= dev_nxt;
      out_sector_r <= sector_nxt;
      out_bytes_r  <= bytes_nxt;
      out_last_r   <= !split;
      out_cval_r   <= s1_action_r ? cval_rd : '0;
    end
    if (s1_adv && split) begin
      sec_sector_r <= sec_sector_nxt;
      sec_bytes_r  <= second_bytes;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_target_device = out_dev_r;
  assign out_sector        = out_sector_r;
  assign out_bytes         = out_bytes_r;
  assign out_last          = out_last_r;
  assign out_counter_value = out_cval_r;

  `HVRR_ASSERT(a_sec_behind_first,
               sec_valid_r |-> out_valid_r && !out_last_r,
               "second piece without its first")
  `HVRR_ASSERT(a_cval_zero,
               out_valid_r && out_kind_r != hvrr_pkg::KIND_COUNTER |-> out_cval_r == '0,
               "counter value leaked")
  `HVRR_ASSERT(a_split_next,
               sec_move |=> out_valid_r && out_last_r && out_dev_r,
               "second piece not presented")

endmodule
